@@ hdl/gmis_pkg.sv @@
// ---------------------------------------------------------------------------
// gmis_pkg
// Types and constants shared by the greedy maximal independent set block.
// ---------------------------------------------------------------------------
package gmis_pkg;

   localparam int ID_WIDTH    = 16;
   localparam int ID_SPACE    = 65536;
   localparam int COUNT_WIDTH = 17;

   typedef enum logic [1:0] {
      FLAG_UNMATCHED = 2'd0,
      FLAG_EXCLUDED  = 2'd1,
      FLAG_IN_SET    = 2'd2
   } flag_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE,
      ST_DECIDE,
      ST_WRITEBACK,
      ST_ADMIT
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] node_id;
      logic [ID_WIDTH-1:0] neighbor_id;
      logic                has_edge;
      logic                last_edge;
   } req_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]    result_node;
      logic [1:0]             node_status;
      logic [COUNT_WIDTH-1:0] set_size;
      logic                   degree_overflow;
   } rsp_type;

endpackage

@@ hdl/gmis_ram.sv @@
// ---------------------------------------------------------------------------
// gmis_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ---------------------------------------------------------------------------
module gmis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/greedy_maximal_independent_set.sv @@
// ---------------------------------------------------------------------------
// greedy_maximal_independent_set
// Serial greedy maximal independent set over a node flag memory.
// ---------------------------------------------------------------------------
// Items are taken while busy is low. An item with an edge does one flag memory
// read of its neighbor; an item without edge that is not last leaves busy low.
// A last item adds the node flag read, and on admission one write-back per
// buffered neighbor plus the node write, all through the single flag memory
// write port. A result shows on rsp_data for one cycle with rsp_strobe and
// cannot be stalled. After reset all min(NODE_COUNT, 65536) flag memory
// entries are cleared with busy high.
module greedy_maximal_independent_set #(
   parameter int NODE_COUNT = 65536,
   parameter int MAX_DEGREE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gmis_pkg::req_type req_data,
   output logic              rsp_strobe,
   output gmis_pkg::rsp_type rsp_data
);

   localparam int FDEPTH = (NODE_COUNT < gmis_pkg::ID_SPACE) ? NODE_COUNT : gmis_pkg::ID_SPACE;
   localparam int FAW    = $clog2(FDEPTH);
   localparam int CW     = $clog2(MAX_DEGREE + 1);
   localparam int BAW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

   function automatic logic id_ok(input logic [gmis_pkg::ID_WIDTH-1:0] id);
      return (32'(id) < 32'(NODE_COUNT));
   endfunction

   gmis_pkg::state_type state_ff, state_in;
   logic [FAW-1:0] clear_addr_ff, clear_addr_in;
   gmis_pkg::req_type req_ff, req_in;
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] wb_idx_ff, wb_idx_in;
   logic [CW-1:0] wb_next;
   logic blocked_ff, blocked_in;
   logic ovf_ff, ovf_in;
   logic [gmis_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   gmis_pkg::rsp_type rsp_ff, rsp_in;
   logic admit;

   logic           flag_we;
   logic [FAW-1:0] flag_waddr;
   logic [1:0]     flag_wdata;
   logic [FAW-1:0] flag_raddr;
   logic [1:0]     flag_rdata;
   logic           buf_we;
   logic [BAW-1:0] buf_waddr;
   logic [gmis_pkg::ID_WIDTH-1:0] buf_wdata;
   logic [BAW-1:0] buf_raddr;
   logic [gmis_pkg::ID_WIDTH-1:0] buf_rdata;

   gmis_ram #(.WIDTH(2), .DEPTH(FDEPTH)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rdata)
   );

   gmis_ram #(.WIDTH(gmis_pkg::ID_WIDTH), .DEPTH(MAX_DEGREE)) u_nbr_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   assign wb_next = wb_idx_ff + 1'b1;
   assign admit   = id_ok(req_ff.node_id) && (flag_rdata == gmis_pkg::FLAG_UNMATCHED)
                    && !blocked_ff && !ovf_ff;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      req_in        = req_ff;
      edge_count_in = edge_count_ff;
      wb_idx_in     = wb_idx_ff;
      blocked_in    = blocked_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      flag_we       = 1'b0;
      flag_waddr    = clear_addr_ff;
      flag_wdata    = gmis_pkg::FLAG_UNMATCHED;
      flag_raddr    = req_ff.node_id[FAW-1:0];
      buf_we        = 1'b0;
      buf_waddr     = edge_count_ff[BAW-1:0];
      buf_wdata     = req_data.neighbor_id;
      buf_raddr     = '0;
      case (state_ff)
         gmis_pkg::ST_CLEAR: begin
            flag_we       = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == FAW'(FDEPTH - 1)) begin
               state_in = gmis_pkg::ST_IDLE;
            end
         end
         gmis_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.has_edge) begin
                  flag_raddr = req_data.neighbor_id[FAW-1:0];
                  if (edge_count_ff < CW'(MAX_DEGREE)) begin
                     buf_we        = 1'b1;
                     edge_count_in = edge_count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = gmis_pkg::ST_EDGE;
               end else if (req_data.last_edge) begin
                  flag_raddr = req_data.node_id[FAW-1:0];
                  state_in   = gmis_pkg::ST_DECIDE;
               end
            end
         end
         gmis_pkg::ST_EDGE: begin
            if (id_ok(req_ff.neighbor_id) && flag_rdata == gmis_pkg::FLAG_IN_SET) begin
               blocked_in = 1'b1;
            end
            if (req_ff.last_edge) begin
               state_in = gmis_pkg::ST_DECIDE;
            end else begin
               state_in = gmis_pkg::ST_IDLE;
            end
         end
         gmis_pkg::ST_DECIDE: begin
            wb_idx_in = '0;
            if (admit) begin
               if (edge_count_ff == '0) begin
                  state_in = gmis_pkg::ST_ADMIT;
               end else begin
                  state_in = gmis_pkg::ST_WRITEBACK;
               end
            end else begin
               rsp_strobe_in          = 1'b1;
               rsp_in.result_node     = req_ff.node_id;
               rsp_in.node_status     = id_ok(req_ff.node_id) ? flag_rdata
                                                              : gmis_pkg::FLAG_UNMATCHED;
               rsp_in.set_size        = count_ff;
               rsp_in.degree_overflow = ovf_ff;
               edge_count_in          = '0;
               blocked_in             = 1'b0;
               ovf_in                 = 1'b0;
               state_in               = gmis_pkg::ST_IDLE;
            end
         end
         gmis_pkg::ST_WRITEBACK: begin
            if (id_ok(buf_rdata)) begin
               flag_we    = 1'b1;
               flag_waddr = buf_rdata[FAW-1:0];
               flag_wdata = gmis_pkg::FLAG_EXCLUDED;
            end
            wb_idx_in = wb_next;
            buf_raddr = wb_next[BAW-1:0];
            if (wb_next == edge_count_ff) begin
               state_in = gmis_pkg::ST_ADMIT;
            end
         end
         gmis_pkg::ST_ADMIT: begin
            flag_we    = 1'b1;
            flag_waddr = req_ff.node_id[FAW-1:0];
            flag_wdata = gmis_pkg::FLAG_IN_SET;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            rsp_strobe_in          = 1'b1;
            rsp_in.result_node     = req_ff.node_id;
            rsp_in.node_status     = gmis_pkg::FLAG_IN_SET;
            rsp_in.set_size        = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
            rsp_in.degree_overflow = 1'b0;
            edge_count_in          = '0;
            blocked_in             = 1'b0;
            ovf_in                 = 1'b0;
            state_in               = gmis_pkg::ST_IDLE;
         end
         default: begin
            state_in = gmis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gmis_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         edge_count_ff <= '0;
         wb_idx_ff     <= '0;
         blocked_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         edge_count_ff <= edge_count_in;
         wb_idx_ff     <= wb_idx_in;
         blocked_ff    <= blocked_in;
         ovf_ff        <= ovf_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != gmis_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // results never come on consecutive cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // set size only grows
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("admitted count decreased");

   // write-back only for a clean run with buffered neighbors
   a_wb_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == gmis_pkg::ST_WRITEBACK |-> edge_count_ff != '0 && !ovf_ff && !blocked_ff)
      else $error("write-back on a run that cannot be admitted");

   // reported status is a valid flag
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.node_status != 2'd3)
      else $error("invalid node status");

endmodule
